// ----- sv/fsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_pkg
// shared constants, types and command words for the frustum culling block
// ----------------------------------------------------------------------------
package fsc_pkg;

	localparam int MAX_EYES    = 2;
	localparam int EYE_W       = (MAX_EYES > 1) ? $clog2(MAX_EYES) : 1;
	localparam int ACC_W       = 66;
	localparam int SQ_STEPS    = 32;
	localparam int DIV_STEPS   = 48;
	localparam int PLANE_WORDS = MAX_EYES * 24;
	localparam int PA_W        = $clog2(PLANE_WORDS);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef logic signed [31:0] q16_t;

	// datapath command word, one per cycle from the controller
	typedef struct packed {
		logic             cap;
		logic             row_wr;
		logic             plane_init;
		logic             acc_clr;
		logic             acc_init;
		logic             acc_add;
		logic             mul_en;
		logic             test_mode;
		logic             sq_init;
		logic             sq_step;
		logic             div_init;
		logic             div_step;
		logic             div_store;
		logic             plane_wr;
		logic             ok_set;
		logic             ok_eval;
		logic             vis_init;
		logic             vis_init_val;
		logic             vis_or;
		logic             out_load;
		logic [1:0]       k;
		logic [1:0]       rk;
		logic [2:0]       p;
		logic [EYE_W-1:0] eye;
	} fsc_cmd_t;

	typedef struct packed {
		logic root_zero;
	} fsc_stat_t;

endpackage

// ----- sv/fsc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_dp
// datapath: matrix rows, plane store, shared multiplier, sqrt and divider
// ----------------------------------------------------------------------------
module fsc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fsc_pkg::fsc_cmd_t   c,
	output fsc_pkg::fsc_stat_t  st,
	input  logic                eye,
	input  logic [1:0]          row_index,
	input  logic signed [31:0]  coef_0,
	input  logic signed [31:0]  coef_1,
	input  logic signed [31:0]  coef_2,
	input  logic signed [31:0]  coef_3,
	input  logic signed [31:0]  center_x,
	input  logic signed [31:0]  center_y,
	input  logic signed [31:0]  center_z,
	input  logic [30:0]         sphere_radius,
	output logic                visible
);
	localparam int EW = fsc_pkg::EYE_W;
	localparam int AW = fsc_pkg::ACC_W;
	localparam int PW = fsc_pkg::PA_W;

	function automatic fsc_pkg::q16_t sat_add(fsc_pkg::q16_t a, fsc_pkg::q16_t b,
		logic sub);
		logic [32:0] s;
		s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[31:0];
	endfunction

	fsc_pkg::q16_t mat_q   [fsc_pkg::MAX_EYES][4][4];
	fsc_pkg::q16_t comp_q  [4];
	fsc_pkg::q16_t raw     [4];

	logic [EW-1:0]          beye_q;
	fsc_pkg::q16_t          cx_q, cy_q, cz_q;
	logic [30:0]            rad_q;
	logic signed [63:0]     prod_q;
	logic signed [AW-1:0]   acc_q;
	logic [63:0]            sqv_q;
	logic [35:0]            rem_q;
	logic [31:0]            root_q;
	logic [31:0]            drem_q;
	logic [47:0]            dvd_q;
	logic                   eye_ok_q, vis_q, visible_q;
	logic                   pl_vld_q [fsc_pkg::MAX_EYES][6];
	logic                   pl_rvld_q;

	fsc_pkg::q16_t          op_a, op_b, ctr, xk;
	logic [35:0]            rem_sh, trial;
	logic [32:0]            dt;
	logic                   dge;
	logic [31:0]            xmag;
	fsc_pkg::q16_t          nres;
	logic [PW-1:0]          pl_waddr, pl_raddr;
	fsc_pkg::q16_t          pl_rdata, pl_word;

	// raw plane components of the plane being built
	always_comb begin
		for (int kk = 0; kk < 4; kk++) begin
			unique case (c.p)
				3'd0:    raw[kk] = sat_add(mat_q[beye_q][3][kk], mat_q[beye_q][0][kk], 1'b0);
				3'd1:    raw[kk] = sat_add(mat_q[beye_q][3][kk], mat_q[beye_q][0][kk], 1'b1);
				3'd2:    raw[kk] = sat_add(mat_q[beye_q][3][kk], mat_q[beye_q][1][kk], 1'b0);
				3'd3:    raw[kk] = sat_add(mat_q[beye_q][3][kk], mat_q[beye_q][1][kk], 1'b1);
				3'd4:    raw[kk] = mat_q[beye_q][2][kk];
				3'd5:    raw[kk] = sat_add(mat_q[beye_q][3][kk], mat_q[beye_q][2][kk], 1'b1);
				default: raw[kk] = '0;
			endcase
		end
	end

	// plane store addressing: 24 words per eye, 4 per plane
	assign pl_waddr = PW'(beye_q) * PW'(24) + PW'({c.p, c.k});
	assign pl_raddr = PW'(c.eye) * PW'(24) + PW'({c.p, c.rk});
	assign pl_word  = pl_rvld_q ? pl_rdata : '0;

	fsc_ram #(
		.WIDTH (32),
		.DEPTH (fsc_pkg::PLANE_WORDS)
	) u_planes (
		.clk   (clk),
		.wr_en (c.plane_wr),
		.waddr (pl_waddr),
		.wdata (comp_q[c.k]),
		.raddr (pl_raddr),
		.rdata (pl_rdata)
	);

	always_comb begin
		unique case (c.k)
			2'd0:    ctr = cx_q;
			2'd1:    ctr = cy_q;
			default: ctr = cz_q;
		endcase
		op_a = c.test_mode ? pl_word : comp_q[c.k];
		op_b = c.test_mode ? ctr : comp_q[c.k];
	end

	// sqrt and divider step logic
	always_comb begin
		rem_sh = {rem_q[33:0], sqv_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		dt     = {drem_q, dvd_q[47]};
		dge    = dt >= {1'b0, root_q};
		xk     = comp_q[c.k];
		xmag   = xk[31] ? (32'd0 - xk) : xk;
		if (xk[31]) begin
			nres = (dvd_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(48'd0 - dvd_q);
		end else begin
			nres = (dvd_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd_q[31:0];
		end
	end

	assign st.root_zero = (root_q == '0);

	// matrix rows, undefined until written
	always_ff @(posedge clk) begin
		if (c.row_wr) begin
			mat_q[EW'(eye)][row_index] <= '{coef_0, coef_1, coef_2, coef_3};
		end
	end

	always_ff @(posedge clk) begin
		if (c.cap) begin
			beye_q <= EW'(eye);
			cx_q   <= center_x;
			cy_q   <= center_y;
			cz_q   <= center_z;
			rad_q  <= sphere_radius;
		end
		if (c.plane_init) begin
			comp_q <= raw;
		end else if (c.div_store) begin
			comp_q[c.k] <= nres;
		end
		if (c.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (c.acc_clr) begin
			acc_q <= '0;
		end else if (c.acc_init) begin
			acc_q <= AW'(pl_word) + {{(AW-31){1'b0}}, rad_q};
		end else if (c.acc_add) begin
			acc_q <= c.test_mode ? (acc_q + AW'(prod_q >>> 16)) : (acc_q + AW'(prod_q));
		end
		if (c.sq_init) begin
			sqv_q  <= acc_q[63:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (c.sq_step) begin
			sqv_q <= {sqv_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (c.div_init) begin
			dvd_q  <= {xmag, 16'd0};
			drem_q <= '0;
		end else if (c.div_step) begin
			drem_q <= dge ? 32'(dt - {1'b0, root_q}) : dt[31:0];
			dvd_q  <= {dvd_q[46:0], dge};
		end
	end

	// per-plane written flags, an unwritten plane reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_vld_q  <= '{default: 1'b0};
			pl_rvld_q <= 1'b0;
		end else begin
			if (c.plane_wr) begin
				pl_vld_q[beye_q][c.p] <= 1'b1;
			end
			pl_rvld_q <= pl_vld_q[c.eye][c.p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_ok_q  <= 1'b0;
			vis_q     <= 1'b0;
			visible_q <= 1'b0;
		end else begin
			if (c.ok_set) begin
				eye_ok_q <= 1'b1;
			end else if (c.ok_eval) begin
				eye_ok_q <= eye_ok_q & ~acc_q[AW-1];
			end
			if (c.vis_init) begin
				vis_q <= c.vis_init_val;
			end else if (c.vis_or) begin
				vis_q <= vis_q | eye_ok_q;
			end
			if (c.out_load) begin
				visible_q <= vis_q;
			end
		end
	end

	assign visible = visible_q;

endmodule

// ----------------------------------------------------------------------------
// fsc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/fsc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_ctrl
// controller: sequences plane builds and sphere tests, owns the handshakes
// ----------------------------------------------------------------------------
module fsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic                cmd,
	input  logic                eye,
	input  logic [1:0]          row_index,
	input  logic [1:0]          eye_count,
	input  fsc_pkg::fsc_stat_t  st,
	output fsc_pkg::fsc_cmd_t   c
);
	localparam int EW = fsc_pkg::EYE_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PINIT  = 4'd1;
	localparam logic [3:0] S_SQ     = 4'd2;
	localparam logic [3:0] S_SQRT_I = 4'd3;
	localparam logic [3:0] S_SQRT   = 4'd4;
	localparam logic [3:0] S_DIV_I  = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_DIV_ST = 4'd7;
	localparam logic [3:0] S_WR     = 4'd8;
	localparam logic [3:0] S_TSTART = 4'd9;
	localparam logic [3:0] S_TINIT  = 4'd10;
	localparam logic [3:0] S_TMUL   = 4'd11;
	localparam logic [3:0] S_TEVAL  = 4'd12;
	localparam logic [3:0] S_TEYE   = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;
	localparam logic [3:0] S_TACC   = 4'd15;

	logic [3:0]    state_q, state_d;
	logic [1:0]    k_q, k_d;
	logic [2:0]    p_q, p_d;
	logic [EW-1:0] eye_q, eye_d;
	logic [5:0]    it_q, it_d;
	logic          ov_q;
	logic [2:0]    n;
	logic          eye_in, eye_last, slot_free;

	assign n         = (int'(eye_count) > fsc_pkg::MAX_EYES) ? 3'(fsc_pkg::MAX_EYES)
	                                                         : {1'b0, eye_count};
	assign eye_in    = int'(eye) < fsc_pkg::MAX_EYES;
	assign eye_last  = 3'(eye_q) == (n - 3'd1);
	assign slot_free = !ov_q || !out_stall;

	always_comb begin
		c       = '0;
		c.k     = k_q;
		c.p     = p_q;
		c.eye   = eye_q;
		state_d = state_q;
		k_d     = k_q;
		p_d     = p_q;
		eye_d   = eye_q;
		it_d    = it_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					c.cap = 1'b1;
					if (cmd == fsc_pkg::CMD_TEST) begin
						state_d = S_TSTART;
					end else begin
						c.row_wr = eye_in;
						if (eye_in && row_index == 2'd3) begin
							p_d     = '0;
							state_d = S_PINIT;
						end
					end
				end
			end
			S_PINIT: begin
				c.plane_init = 1'b1;
				c.acc_clr    = 1'b1;
				k_d          = '0;
				state_d      = S_SQ;
			end
			S_SQ: begin
				c.mul_en  = k_q != 2'd3;
				c.acc_add = k_q != 2'd0;
				k_d       = k_q + 2'd1;
				if (k_q == 2'd3) begin
					state_d = S_SQRT_I;
				end
			end
			S_SQRT_I: begin
				c.sq_init = 1'b1;
				it_d      = '0;
				state_d   = S_SQRT;
			end
			S_SQRT: begin
				c.sq_step = 1'b1;
				it_d      = it_q + 6'd1;
				if (it_q == 6'(fsc_pkg::SQ_STEPS - 1)) begin
					k_d     = '0;
					state_d = S_DIV_I;
				end
			end
			S_DIV_I: begin
				if (st.root_zero) begin
					state_d = S_WR;
				end else begin
					c.div_init = 1'b1;
					it_d       = '0;
					state_d    = S_DIV;
				end
			end
			S_DIV: begin
				c.div_step = 1'b1;
				it_d       = it_q + 6'd1;
				if (it_q == 6'(fsc_pkg::DIV_STEPS - 1)) begin
					state_d = S_DIV_ST;
				end
			end
			S_DIV_ST: begin
				c.div_store = 1'b1;
				k_d         = k_q + 2'd1;
				state_d     = (k_q == 2'd3) ? S_WR : S_DIV_I;
			end
			// one plane word per cycle into the store
			S_WR: begin
				c.plane_wr = 1'b1;
				k_d        = k_q + 2'd1;
				if (k_q == 2'd3) begin
					p_d     = p_q + 3'd1;
					state_d = (p_q == 3'd5) ? S_IDLE : S_PINIT;
				end
			end
			S_TSTART: begin
				c.vis_init     = 1'b1;
				c.vis_init_val = n == 3'd0;
				c.ok_set       = 1'b1;
				eye_d          = '0;
				p_d            = '0;
				state_d        = (n == 3'd0) ? S_OUT : S_TINIT;
			end
			// fetch w of the plane
			S_TINIT: begin
				c.rk    = 2'd3;
				k_d     = '0;
				state_d = S_TACC;
			end
			// w plus radius into the accumulator, fetch the first coefficient
			S_TACC: begin
				c.acc_init = 1'b1;
				c.rk       = 2'd0;
				state_d    = S_TMUL;
			end
			S_TMUL: begin
				c.test_mode = 1'b1;
				c.mul_en    = k_q != 2'd3;
				c.acc_add   = k_q != 2'd0;
				c.rk        = k_q + 2'd1;
				k_d         = k_q + 2'd1;
				if (k_q == 2'd3) begin
					state_d = S_TEVAL;
				end
			end
			S_TEVAL: begin
				c.ok_eval = 1'b1;
				if (p_q == 3'd5) begin
					p_d     = '0;
					state_d = S_TEYE;
				end else begin
					p_d     = p_q + 3'd1;
					state_d = S_TINIT;
				end
			end
			S_TEYE: begin
				c.vis_or = 1'b1;
				if (eye_last) begin
					state_d = S_OUT;
				end else begin
					c.ok_set = 1'b1;
					eye_d    = eye_q + EW'(1);
					state_d  = S_TINIT;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					c.out_load = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			p_q     <= '0;
			eye_q   <= '0;
			it_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			p_q     <= p_d;
			eye_q   <= eye_d;
			it_q    <= it_d;
			if (c.out_load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = ov_q;

endmodule

// ----- sv/frustum_sphere_culling_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_sphere_culling_top
// frustum plane extraction and bounding sphere culling, signed q16.16
// ----------------------------------------------------------------------------
// A load word (cmd 0) writes one row of an eye's view-projection matrix; a
// row 3 load then builds that eye's six planes (sums and differences of rows,
// the near plane being row 2 alone, each normalized by its xyz length), which
// keeps the block busy: per plane, three squares through the shared
// multiplier, a 32-step bit-serial square root, four 48-step restoring
// divisions (skipped when the length is zero) and four words written into the
// plane store. A test word (cmd 1) runs all six planes of each active eye
// (eye_count of them, capped at two) through the same multiplier; when
// eye_count is zero every sphere is visible. One word is worked on at a time;
// a finished result sits in the output register while the next word is
// already taken. eye_count (apb address 0) should only be written while the
// block is idle.
module frustum_sphere_culling_top (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic               eye,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] coef_0,
	input  logic signed [31:0] coef_1,
	input  logic signed [31:0] coef_2,
	input  logic signed [31:0] coef_3,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        sphere_radius,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible
);
	logic [1:0]         eye_count_q;
	fsc_pkg::fsc_cmd_t  dp_cmd;
	fsc_pkg::fsc_stat_t dp_stat;

	// register file: eye_count only, decoded on the word address
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {30'd0, eye_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_count_q <= 2'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			eye_count_q <= pwdata[1:0];
		end
	end

	// sequencer
	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.eye       (eye),
		.row_index (row_index),
		.eye_count (eye_count_q),
		.st        (dp_stat),
		.c         (dp_cmd)
	);

	// storage and arithmetic
	fsc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.c             (dp_cmd),
		.st            (dp_stat),
		.eye           (eye),
		.row_index     (row_index),
		.coef_0        (coef_0),
		.coef_1        (coef_1),
		.coef_2        (coef_2),
		.coef_3        (coef_3),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.sphere_radius (sphere_radius),
		.visible       (visible)
	);

endmodule

// ----- sim/fsc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_checker
// watches the word channels and the apb port of the frustum culling block,
// rebuilds the planes on each row 3 load and checks every visible flag
// ----------------------------------------------------------------------------
module fsc_checker import fsc_pkg::*; #(
	parameter logic [2:0] EYE_COUNT_ADDR = 3'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic               eye,
	input  logic [1:0]         row_index,
	input  q16_t               coef_0,
	input  q16_t               coef_1,
	input  q16_t               coef_2,
	input  q16_t               coef_3,
	input  q16_t               center_x,
	input  q16_t               center_y,
	input  q16_t               center_z,
	input  logic [30:0]        sphere_radius,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               visible,
	output int                 fail_count,
	output int                 vis_pending,
	output int                 tests_seen,
	output int                 builds_seen,
	output int                 visible_seen
);

	q16_t       rows   [MAX_EYES][4][4];
	q16_t       planes [MAX_EYES][6][4];
	logic [1:0] active_eyes;
	logic       vis_due[$];

	function automatic q16_t sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return q16_t'(v);
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic q16_t scale_by_len(q16_t x, longint unsigned len);
		longint unsigned mag, q;
		mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
		q   = (mag << 16) / len;
		if (x < 0) begin
			if (q > 64'h80000000)
				q = 64'h80000000;
			return sat32(-longint'(q));
		end
		if (q > 64'h7fffffff)
			q = 64'h7fffffff;
		return q16_t'(q);
	endfunction

	task automatic build_planes(int e);
		longint r0, r1, r2, r3;
		longint unsigned a, b, c, len;
		for (int k = 0; k < 4; k++) begin
			r0 = rows[e][0][k];
			r1 = rows[e][1][k];
			r2 = rows[e][2][k];
			r3 = rows[e][3][k];
			planes[e][0][k] = sat32(r3 + r0);
			planes[e][1][k] = sat32(r3 - r0);
			planes[e][2][k] = sat32(r3 + r1);
			planes[e][3][k] = sat32(r3 - r1);
			planes[e][4][k] = sat32(r2);
			planes[e][5][k] = sat32(r3 - r2);
		end
		for (int p = 0; p < 6; p++) begin
			a   = longint'(planes[e][p][0]) * longint'(planes[e][p][0]);
			b   = longint'(planes[e][p][1]) * longint'(planes[e][p][1]);
			c   = longint'(planes[e][p][2]) * longint'(planes[e][p][2]);
			len = root64(a + b + c);
			if (len != 0)
				for (int k = 0; k < 4; k++)
					planes[e][p][k] = scale_by_len(planes[e][p][k], len);
		end
	endtask

	function automatic logic sphere_touches(int e, q16_t cx, q16_t cy, q16_t cz,
			logic [30:0] r);
		longint d;
		for (int p = 0; p < 6; p++) begin
			// each product floored to q16.16 by arithmetic shift
			d = ((longint'(planes[e][p][0]) * longint'(cx)) >>> 16)
			  + ((longint'(planes[e][p][1]) * longint'(cy)) >>> 16)
			  + ((longint'(planes[e][p][2]) * longint'(cz)) >>> 16)
			  + longint'(planes[e][p][3]) + longint'({1'b0, r});
			if (d < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int   n;
		logic vis;
		if (!arst_n) begin
			active_eyes  = '0;
			vis_due.delete();
			vis_pending  = 0;
			fail_count   = 0;
			tests_seen   = 0;
			builds_seen  = 0;
			visible_seen = 0;
			for (int e = 0; e < MAX_EYES; e++)
				for (int p = 0; p < 6; p++)
					for (int k = 0; k < 4; k++)
						planes[e][p][k] = '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == EYE_COUNT_ADDR)
				active_eyes = pwdata[1:0];
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					rows[eye][row_index][0] = coef_0;
					rows[eye][row_index][1] = coef_1;
					rows[eye][row_index][2] = coef_2;
					rows[eye][row_index][3] = coef_3;
					if (row_index == 2'd3) begin
						build_planes(eye);
						builds_seen++;
					end
				end else begin
					n   = (active_eyes > MAX_EYES) ? MAX_EYES : active_eyes;
					vis = (n == 0);
					for (int e = 0; e < n && !vis; e++)
						if (sphere_touches(e, center_x, center_y, center_z, sphere_radius))
							vis = 1'b1;
					vis_due.push_back(vis);
				end
			end
			if (out_valid && !out_stall) begin
				if (vis_due.size() == 0) begin
					$error("visible word with nothing expected: actual %0b", visible);
					fail_count++;
				end else begin
					vis = vis_due.pop_front();
					tests_seen++;
					visible_seen += visible;
					if (visible !== vis) begin
						$error("visible: expected %0b actual %0b", vis, visible);
						fail_count++;
					end
				end
			end
			vis_pending = vis_due.size();
		end
	end

endmodule

// ----- sim/frustum_sphere_culling_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_sphere_culling_top_test
// stimulus and verdict for the frustum sphere culling block
// ----------------------------------------------------------------------------
// Loads full view-projection matrices for both eyes (plus stray rows), fires
// sphere tests across several eye_count settings and idle patterns, holds the
// result side off for a long stretch once, and lets fsc_checker compare every
// visible flag against its own plane predictor.
module frustum_sphere_culling_top_test;
	import fsc_pkg::*;

	localparam logic [2:0] EYE_COUNT_ADDR = 3'd0;
	localparam int         ONE            = 32'sh00010000;
	localparam int         BUILD_SETTLE   = 1600;   // longest plane build plus margin
	localparam int         WATCHDOG_LIMIT = 20000;
	localparam int         RANDOM_PER_PHASE = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic cmd = CMD_LOAD, eye = 1'b0;
	logic [1:0] row_index = '0;
	q16_t coef_0 = '0, coef_1 = '0, coef_2 = '0, coef_3 = '0;
	q16_t center_x = '0, center_y = '0, center_z = '0;
	logic [30:0] sphere_radius = '0;
	logic out_valid, visible;
	logic out_stall = 1'b0;

	int fail_count, vis_pending, tests_seen, builds_seen, visible_seen;
	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int hold_request   = 0;  // cycles the result side should hold off
	int quiet_cycles   = 0;

	always #10 clk = ~clk;

	frustum_sphere_culling_top dut (.*);

	fsc_checker #(.EYE_COUNT_ADDR(EYE_COUNT_ADDR)) chk (.*);

	// result side: random stall, or one long hold-off counted here
	always @(posedge clk) begin
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word accepted for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// present one word, optionally after a random gap, and wait for it to be taken
	task automatic send_word(logic c, logic e, logic [1:0] r, q16_t k0, q16_t k1,
			q16_t k2, q16_t k3, q16_t cx, q16_t cy, q16_t cz, logic [30:0] rad);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		eye           <= e;
		row_index     <= r;
		coef_0        <= k0;
		coef_1        <= k1;
		coef_2        <= k2;
		coef_3        <= k3;
		center_x      <= cx;
		center_y      <= cy;
		center_z      <= cz;
		sphere_radius <= rad;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_row(logic e, logic [1:0] r, q16_t k0, q16_t k1, q16_t k2, q16_t k3);
		// sphere fields carry noise, the block must ignore them
		send_word(CMD_LOAD, e, r, k0, k1, k2, k3, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic test_sphere(q16_t cx, q16_t cy, q16_t cz, logic [30:0] rad);
		send_word(CMD_TEST, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			cx, cy, cz, rad);
	endtask

	// coefficient: mostly modest values, sometimes extremes or raw bits
	function automatic q16_t pick_coef();
		case ($urandom_range(9))
			0:       return $urandom;
			1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			2:       return '0;
			default: return q16_t'($urandom_range(6 * ONE)) - 3 * ONE;
		endcase
	endfunction

	function automatic q16_t pick_coord();
		case ($urandom_range(7))
			0:       return $urandom;
			1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return q16_t'($urandom_range(8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	function automatic logic [30:0] pick_radius();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return 31'h7fffffff;
			2:       return '0;
			default: return $urandom_range(2 * ONE);
		endcase
	endfunction

	task automatic load_matrix(logic e);
		for (int r = 0; r < 4; r++)
			load_row(e, r, pick_coef(), pick_coef(), pick_coef(), pick_coef());
	endtask

	// drain results, then let a possible plane build finish before touching eye_count
	task automatic settle_and_config(logic [1:0] eyes);
		in_valid <= 1'b0;
		while (vis_pending != 0)
			@(posedge clk);
		repeat (BUILD_SETTLE) @(posedge clk);
		apb_write(EYE_COUNT_ADDR, {30'd0, eyes});
	endtask

	task automatic random_phase(int words, bit long_hold, bit mid_drain);
		for (int i = 0; i < words; i++) begin
			if (long_hold && i == 20)
				hold_request = 400;
			if (mid_drain && i == words / 2)
				while (vis_pending != 0) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			case ($urandom_range(19))
				0, 1: begin
					load_matrix($urandom);
					i += 3;
				end
				// stray row, a row 3 one reuses whatever rows the eye holds
				2: load_row($urandom, $urandom, pick_coef(), pick_coef(), pick_coef(),
					pick_coef());
				default: test_sphere(pick_coord(), pick_coord(), pick_coord(), pick_radius());
			endcase
		end
	endtask

	initial begin
		logic [1:0] phase_eyes[5] = '{2'd2, 2'd1, 2'd3, 2'd2, 2'd0};
		int         idle_mode[5][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{7, 7}, '{55, 55}};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// eye_count still zero after reset: everything visible
		test_sphere(32'sh7fffffff, 32'sh80000000, '0, '0);

		// eye 0: identity matrix, planes are the unit cube |x|,|y|,|z| <= 1 (near z >= 0)
		load_row(1'b0, 2'd0, ONE, 0, 0, 0);
		load_row(1'b0, 2'd1, 0, ONE, 0, 0);
		load_row(1'b0, 2'd2, 0, 0, ONE, 0);
		load_row(1'b0, 2'd3, 0, 0, 0, ONE);
		// eye 1: extreme rows, sums saturate and the near plane has zero length
		load_row(1'b1, 2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		load_row(1'b1, 2'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		load_row(1'b1, 2'd2, 0, 0, 0, 0);
		load_row(1'b1, 2'd3, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);

		settle_and_config(2'd1);
		test_sphere(0, 0, ONE / 2, 0);
		test_sphere(3 * ONE, 0, ONE / 2, 0);
		test_sphere(3 * ONE, 0, ONE / 2, 31'h7fffffff);
		test_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		test_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
		test_sphere(0, 0, -ONE / 4, ONE / 8);
		test_sphere(0, 0, -ONE / 4, ONE / 2);

		settle_and_config(2'd2);
		test_sphere(0, 0, ONE / 2, 0);
		test_sphere(5 * ONE, -5 * ONE, 0, ONE);
		test_sphere(32'sh80000000, 32'sh7fffffff, 0, 0);
		// stale rows: only row 3 of eye 0 replaced, rows 0..2 reused
		load_row(1'b0, 2'd3, 0, 0, 0, 2 * ONE);
		test_sphere(ONE + ONE / 2, 0, ONE / 2, 0);

		for (int ph = 0; ph < 5; ph++) begin
			settle_and_config(phase_eyes[ph]);
			send_idle_pct = idle_mode[ph][0];
			stall_pct     = idle_mode[ph][1];
			random_phase(RANDOM_PER_PHASE, ph == 1, ph == 3);
		end

		in_valid <= 1'b0;
		while (vis_pending != 0)
			@(posedge clk);
		repeat (BUILD_SETTLE) @(posedge clk);

		$display("checked %0d sphere tests (%0d visible) across %0d plane builds,",
			tests_seen, visible_seen, builds_seen);
		$display("eye_count 0..3 with idle, stall and long hold-off phases");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/fsc_pkg.sv
sv/fsc_dp.sv
sv/fsc_ctrl.sv
sv/frustum_sphere_culling_top.sv
sim/fsc_checker.sv
sim/frustum_sphere_culling_top_test.sv
